/* rtl/tcd_pkg.sv */
// tcd_pkg: shared types, constants and floor-mask helpers for the two-car
// elevator dispatcher. No dependencies.
`timescale 1ns / 1ps

package tcd_pkg;

  localparam int FloorCount = 3;
  localparam int FloorW     = 2;
  localparam int HallW      = 2 * FloorCount - 2;
  localparam int HeldW      = 2 * FloorCount + HallW;

  typedef logic [FloorW-1:0]     floor_t;
  typedef logic [FloorCount-1:0] car_req_t;
  typedef logic [HallW-1:0]      hall_req_t;

  typedef enum logic [1:0] {
    DirIdle = 2'd0,
    DirUp   = 2'd1,
    DirDown = 2'd2
  } dir_t;

  typedef struct packed {
    dir_t     mode;
    floor_t   pos;
    car_req_t req;
    dir_t     motor;
  } car_state_t;

  function automatic car_req_t car_bit(input int f);
    car_req_t r;
    r = '0;
    if (f >= 1 && f <= FloorCount) begin
      r[f-1] = 1'b1;
    end
    return r;
  endfunction

  function automatic hall_req_t up_bit(input int f);
    hall_req_t r;
    r = '0;
    if (f >= 1 && f < FloorCount) begin
      r[2*f-2] = 1'b1;
    end
    return r;
  endfunction

  function automatic hall_req_t down_bit(input int f);
    hall_req_t r;
    r = '0;
    if (f >= 2 && f <= FloorCount) begin
      r[2*f-3] = 1'b1;
    end
    return r;
  endfunction

  function automatic hall_req_t hall_at(input int f);
    return up_bit(f) | down_bit(f);
  endfunction

  function automatic int floor_gap(input int a, input int b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

/* rtl/tcd_in_if.sv */
// tcd_in_if: input channel carrying one beat of raw button levels.
// Depends on tcd_pkg.
`timescale 1ns / 1ps

interface tcd_in_if
  import tcd_pkg::*;
();
  logic      valid;
  logic      ready;
  car_req_t  left_car_keys;
  car_req_t  right_car_keys;
  hall_req_t hall_keys;

  modport source (output valid, output left_car_keys, output right_car_keys,
                  output hall_keys, input ready);
  modport sink   (input valid, input left_car_keys, input right_car_keys,
                  input hall_keys, output ready);
endinterface

/* rtl/tcd_out_if.sv */
// tcd_out_if: result channel carrying one beat of car status and lamps.
// Depends on tcd_pkg.
`timescale 1ns / 1ps

interface tcd_out_if
  import tcd_pkg::*;
();
  logic      valid;
  logic      ready;
  floor_t    left_floor;
  floor_t    right_floor;
  dir_t      left_direction;
  dir_t      right_direction;
  dir_t      left_motor;
  dir_t      right_motor;
  logic      left_door_cycle;
  logic      right_door_cycle;
  car_req_t  left_car_lamps;
  car_req_t  right_car_lamps;
  hall_req_t hall_lamps;

  modport source (output valid, output left_floor, output right_floor,
                  output left_direction, output right_direction,
                  output left_motor, output right_motor,
                  output left_door_cycle, output right_door_cycle,
                  output left_car_lamps, output right_car_lamps,
                  output hall_lamps, input ready);
  modport sink   (input valid, input left_floor, input right_floor,
                  input left_direction, input right_direction,
                  input left_motor, input right_motor,
                  input left_door_cycle, input right_door_cycle,
                  input left_car_lamps, input right_car_lamps,
                  input hall_lamps, output ready);
endinterface

/* rtl/tcd_car_step.sv */
// tcd_car_step: one car's tick - idle stop and direction choice, or a
// one-floor move with stop, continue or go idle. Depends on tcd_pkg.
`timescale 1ns / 1ps

module tcd_car_step
  import tcd_pkg::*;
(
  input  car_state_t cur,
  input  hall_req_t  hall_in,
  input  dir_t       other_mode,
  input  floor_t     other_pos,
  output car_state_t nxt,
  output hall_req_t  hall_out,
  output logic       door
);

  always_comb begin
    int   fp;
    int   np;
    logic up_car;
    logic dn_car;
    logic up_hall;
    logic dn_hall;
    logic take;
    logic cont;
    nxt      = cur;
    hall_out = hall_in;
    door     = 1'b0;
    fp       = int'(cur.pos);
    np       = fp;
    up_car   = 1'b0;
    dn_car   = 1'b0;
    up_hall  = 1'b0;
    dn_hall  = 1'b0;
    take     = 1'b0;
    cont     = 1'b0;
    unique case (cur.mode)
      DirIdle: begin
        if ((cur.req & car_bit(fp)) != '0 || (hall_in & hall_at(fp)) != '0) begin
          nxt.req  = cur.req & ~car_bit(fp);
          hall_out = hall_in & ~hall_at(fp);
          door     = 1'b1;
        end
        for (int f = 1; f <= FloorCount; f++) begin
          if (f > fp && (nxt.req & car_bit(f)) != '0) up_car = 1'b1;
          if (f < fp && (nxt.req & car_bit(f)) != '0) dn_car = 1'b1;
          take = (hall_out & hall_at(f)) != '0 &&
                 (other_mode != DirIdle ||
                  floor_gap(fp, f) <= floor_gap(int'(other_pos), f));
          if (f > fp && take) up_hall = 1'b1;
          if (f < fp && take) dn_hall = 1'b1;
        end
        priority if (up_car) begin
          nxt.mode = DirUp;
        end else if (dn_car) begin
          nxt.mode = DirDown;
        end else if (up_hall) begin
          nxt.mode = DirUp;
        end else if (dn_hall) begin
          nxt.mode = DirDown;
        end
      end
      DirUp: begin
        if (fp >= FloorCount) begin
          nxt.mode  = DirIdle;
          nxt.motor = DirIdle;
        end else begin
          np      = fp + 1;
          nxt.pos = floor_t'(np);
          if ((cur.req & car_bit(np)) != '0 || (hall_in & up_bit(np)) != '0) begin
            nxt.req  = cur.req & ~car_bit(np);
            hall_out = hall_in & ~up_bit(np);
            door     = 1'b1;
          end
          for (int f = 1; f <= FloorCount; f++) begin
            if (f > np && ((nxt.req & car_bit(f)) != '0 ||
                           (hall_out & up_bit(f)) != '0)) cont = 1'b1;
          end
          if (cont) begin
            nxt.motor = DirUp;
          end else begin
            nxt.mode  = DirIdle;
            nxt.motor = DirIdle;
          end
        end
      end
      default: begin
        if (fp <= 1 || fp > FloorCount) begin
          nxt.mode  = DirIdle;
          nxt.motor = DirIdle;
        end else begin
          np      = fp - 1;
          nxt.pos = floor_t'(np);
          if ((cur.req & car_bit(np)) != '0 || (hall_in & down_bit(np)) != '0) begin
            nxt.req  = cur.req & ~car_bit(np);
            hall_out = hall_in & ~down_bit(np);
            door     = 1'b1;
          end
          for (int f = 1; f <= FloorCount; f++) begin
            if (f < np && ((nxt.req & car_bit(f)) != '0 ||
                           (hall_out & down_bit(f)) != '0)) cont = 1'b1;
          end
          if (cont) begin
            nxt.motor = DirDown;
          end else begin
            nxt.mode  = DirIdle;
            nxt.motor = DirIdle;
          end
        end
      end
    endcase
  end

endmodule

/* rtl/two_car_elevator_dispatcher_unit.sv */
// Two-car elevator dispatcher: an input beat passes the input register, then
// one pass through button latch and both car steps into the result register.
// Throughput one beat per cycle unless a held result waits on rsp.ready; the
// single pass updates all dispatch state in the same cycle as the result.
// Reset (rst, synchronous) empties both registers, clears requests and held
// buttons, sets both cars idle at floor 1 with motors off.
// Depends on tcd_pkg, tcd_in_if, tcd_out_if, tcd_car_step.
`timescale 1ns / 1ps

module two_car_elevator_dispatcher_unit
  import tcd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  tcd_in_if.sink    cmd,
  tcd_out_if.source rsp
);

  // input register
  logic      s1_valid;
  car_req_t  s1_lk;
  car_req_t  s1_rk;
  hall_req_t s1_hk;

  // dispatch state
  logic [HeldW-1:0] held;
  hall_req_t        hall_req;
  car_state_t       left_car;
  car_state_t       right_car;

  // result register
  logic      o_valid;
  floor_t    o_lf;
  floor_t    o_rf;
  dir_t      o_ldir;
  dir_t      o_rdir;
  dir_t      o_lmot;
  dir_t      o_rmot;
  logic      o_ldoor;
  logic      o_rdoor;
  car_req_t  o_llamp;
  car_req_t  o_rlamp;
  hall_req_t o_hlamp;

  logic             advance;
  logic [HeldW-1:0] levels;
  logic [HeldW-1:0] released;
  car_state_t       left_latched;
  car_state_t       right_latched;
  hall_req_t        hall_latched;
  car_state_t       right_next;
  car_state_t       left_next;
  hall_req_t        hall_mid;
  hall_req_t        hall_next;
  logic             rdoor;
  logic             ldoor;

  assign advance   = s1_valid && (!o_valid || rsp.ready);
  assign cmd.ready = !s1_valid || advance;

  assign levels   = {s1_hk, s1_rk, s1_lk};
  assign released = held & levels;

  always_comb begin
    left_latched      = left_car;
    right_latched     = right_car;
    left_latched.req  = left_car.req | released[FloorCount-1:0];
    right_latched.req = right_car.req | released[2*FloorCount-1:FloorCount];
    hall_latched      = hall_req | released[HeldW-1:2*FloorCount];
  end

  tcd_car_step u_right (
    .cur        (right_latched),
    .hall_in    (hall_latched),
    .other_mode (left_car.mode),
    .other_pos  (left_car.pos),
    .nxt        (right_next),
    .hall_out   (hall_mid),
    .door       (rdoor)
  );

  tcd_car_step u_left (
    .cur        (left_latched),
    .hall_in    (hall_mid),
    .other_mode (right_next.mode),
    .other_pos  (right_next.pos),
    .nxt        (left_next),
    .hall_out   (hall_next),
    .door       (ldoor)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
    if (cmd.valid && cmd.ready) begin
      s1_lk <= cmd.left_car_keys;
      s1_rk <= cmd.right_car_keys;
      s1_hk <= cmd.hall_keys;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      hall_req  <= '0;
      left_car  <= '{mode: DirIdle, pos: floor_t'(1), req: '0, motor: DirIdle};
      right_car <= '{mode: DirIdle, pos: floor_t'(1), req: '0, motor: DirIdle};
    end else if (advance) begin
      held      <= ~levels;
      hall_req  <= hall_next;
      left_car  <= left_next;
      right_car <= right_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (advance) begin
      o_valid <= 1'b1;
    end else if (rsp.ready) begin
      o_valid <= 1'b0;
    end
    if (advance) begin
      o_lf    <= left_next.pos;
      o_rf    <= right_next.pos;
      o_ldir  <= left_next.mode;
      o_rdir  <= right_next.mode;
      o_lmot  <= left_next.motor;
      o_rmot  <= right_next.motor;
      o_ldoor <= ldoor;
      o_rdoor <= rdoor;
      o_llamp <= left_next.req;
      o_rlamp <= right_next.req;
      o_hlamp <= hall_next;
    end
  end

  assign rsp.valid            = o_valid;
  assign rsp.left_floor       = o_lf;
  assign rsp.right_floor      = o_rf;
  assign rsp.left_direction   = o_ldir;
  assign rsp.right_direction  = o_rdir;
  assign rsp.left_motor       = o_lmot;
  assign rsp.right_motor      = o_rmot;
  assign rsp.left_door_cycle  = o_ldoor;
  assign rsp.right_door_cycle = o_rdoor;
  assign rsp.left_car_lamps   = o_llamp;
  assign rsp.right_car_lamps  = o_rlamp;
  assign rsp.hall_lamps       = o_hlamp;

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    left_car.pos != '0 && int'(left_car.pos) <= FloorCount &&
    right_car.pos != '0 && int'(right_car.pos) <= FloorCount)
    else $error("car position out of range");

  a_advance_result: assert property (@(posedge clk) disable iff (rst)
    advance |=> o_valid)
    else $error("computed beat not presented");

  a_stall_only: assert property (@(posedge clk) disable iff (rst)
    !cmd.ready |-> (s1_valid && o_valid && !rsp.ready))
    else $error("input stalled without output back-pressure");

  a_motor_mode: assert property (@(posedge clk) disable iff (rst)
    o_valid |-> ((o_lmot == DirIdle || o_lmot == o_ldir) &&
                 (o_rmot == DirIdle || o_rmot == o_rdir)))
    else $error("motor drive disagrees with car mode");

  a_door_clears: assert property (@(posedge clk) disable iff (rst)
    (o_valid && o_ldoor) |-> ((o_llamp & car_bit(int'(o_lf))) == '0))
    else $error("left stop left its lamp lit");

endmodule
